/* rtl/qtpe_pkg.sv */
// ----------------------------------------------------------------------------
// qtpe_pkg
// shared types, constants and the step table of the quintic point evaluator
// ----------------------------------------------------------------------------
package qtpe_pkg;

  localparam int unsigned OUT_W    = 40;  // result width, signed
  localparam int unsigned COEF_W   = 32;  // coefficient width, signed
  localparam int unsigned TIME_W   = 24;  // sample time width, unsigned
  localparam int unsigned AMP_W    = 24;  // amplitude port width, signed
  localparam int unsigned AMPI_W   = 25;  // amplitude held one bit wider (reset 1.0)
  localparam int unsigned OPND_W   = 25;  // unsigned multiplier operand
  localparam int unsigned MAG_W    = 40;  // magnitude of a 40 bit signed value
  localparam int unsigned HALF_W   = 20;  // magnitude split into two halves
  localparam int unsigned PROD_W   = HALF_W + OPND_W;
  localparam int unsigned FULL_W   = 64;  // full rounded product
  localparam int unsigned DIV_W    = 3;   // horner divisor 1..5
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_COEF = 6;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned NUM_STEPS = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRACKLE_COEF  = 3'd0,
    REG_SNAP_COEF     = 3'd1,
    REG_JERK_COEF     = 3'd2,
    REG_ACCEL_COEF    = 3'd3,
    REG_VELOCITY_COEF = 3'd4,
    REG_POSITION_COEF = 3'd5,
    REG_AMPLITUDE     = 3'd6
  } qtpe_reg_e;

  // where a finished unit operation goes
  typedef enum logic [2:0] {
    DST_NONE,
    DST_POS,
    DST_VEL,
    DST_ACC,
    DST_JRK,
    DST_SUM
  } qtpe_dest_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DRAIN
  } qtpe_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL0,
    U_MUL1,
    U_DIV,
    U_FIN
  } qtpe_unit_state_e;

  // one operation for the shared unit:
  // sat40(sign * round(|acc| * opnd / (div * 2^F)) + addend)
  typedef struct packed {
    logic signed [OUT_W-1:0]  acc;
    logic [OPND_W-1:0]        opnd;
    logic                     flip;
    logic [DIV_W-1:0]         div;
    logic signed [COEF_W-1:0] addend;
  } qtpe_op_t;

  typedef struct packed {
    logic       first;  // horner chain starts from crackle coefficient
    logic       scale;  // amplitude scaling instead of a horner step
    logic [2:0] k;      // coefficient added after the step
    logic [DIV_W-1:0] d;
    qtpe_dest_e dest;
  } qtpe_step_t;

  // position (n=5), velocity (4), acceleration (3), jerk (2), then four scalings
  function automatic qtpe_step_t step_info(input logic [STEP_W-1:0] s);
    qtpe_step_t r;
    r = '{first: 1'b0, scale: 1'b0, k: 3'd1, d: 3'd1, dest: DST_NONE};
    case (s)
      5'd0:  r = '{first: 1'b1, scale: 1'b0, k: 3'd1, d: 3'd5, dest: DST_NONE};
      5'd1:  r = '{first: 1'b0, scale: 1'b0, k: 3'd2, d: 3'd4, dest: DST_NONE};
      5'd2:  r = '{first: 1'b0, scale: 1'b0, k: 3'd3, d: 3'd3, dest: DST_NONE};
      5'd3:  r = '{first: 1'b0, scale: 1'b0, k: 3'd4, d: 3'd2, dest: DST_NONE};
      5'd4:  r = '{first: 1'b0, scale: 1'b0, k: 3'd5, d: 3'd1, dest: DST_POS};
      5'd5:  r = '{first: 1'b1, scale: 1'b0, k: 3'd1, d: 3'd4, dest: DST_NONE};
      5'd6:  r = '{first: 1'b0, scale: 1'b0, k: 3'd2, d: 3'd3, dest: DST_NONE};
      5'd7:  r = '{first: 1'b0, scale: 1'b0, k: 3'd3, d: 3'd2, dest: DST_NONE};
      5'd8:  r = '{first: 1'b0, scale: 1'b0, k: 3'd4, d: 3'd1, dest: DST_VEL};
      5'd9:  r = '{first: 1'b1, scale: 1'b0, k: 3'd1, d: 3'd3, dest: DST_NONE};
      5'd10: r = '{first: 1'b0, scale: 1'b0, k: 3'd2, d: 3'd2, dest: DST_NONE};
      5'd11: r = '{first: 1'b0, scale: 1'b0, k: 3'd3, d: 3'd1, dest: DST_ACC};
      5'd12: r = '{first: 1'b1, scale: 1'b0, k: 3'd1, d: 3'd2, dest: DST_NONE};
      5'd13: r = '{first: 1'b0, scale: 1'b0, k: 3'd2, d: 3'd1, dest: DST_JRK};
      5'd14: r = '{first: 1'b0, scale: 1'b1, k: 3'd0, d: 3'd1, dest: DST_VEL};
      5'd15: r = '{first: 1'b0, scale: 1'b1, k: 3'd0, d: 3'd1, dest: DST_ACC};
      5'd16: r = '{first: 1'b0, scale: 1'b1, k: 3'd0, d: 3'd1, dest: DST_JRK};
      5'd17: r = '{first: 1'b0, scale: 1'b1, k: 3'd0, d: 3'd1, dest: DST_SUM};
      default: r = '{first: 1'b0, scale: 1'b0, k: 3'd1, d: 3'd1, dest: DST_NONE};
    endcase
    return r;
  endfunction

endpackage

/* rtl/qtpe_unit.sv */
// ----------------------------------------------------------------------------
// qtpe_unit
// shared multiply, round, divide-by-small-constant, add and saturate unit
// ----------------------------------------------------------------------------
module qtpe_unit import qtpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  qtpe_op_t                op_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] res_o
);

  localparam int unsigned QW = FULL_W - FRAC_BITS;   // quotient bits before divide
  localparam int unsigned ND = (QW + 7) / 8;         // radix-256 digits
  localparam int unsigned DW = ND * 8;
  localparam int unsigned SW = DW + 2;
  localparam int unsigned CW = $clog2(ND);

  qtpe_unit_state_e st_q, st_d;
  logic done_q;

  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [OPND_W-1:0]        opnd_q;
  logic [DIV_W-1:0]         d_q;
  logic signed [COEF_W-1:0] add_q;
  logic [PROD_W-1:0]        prod_q;
  logic [DW-1:0]            quo_q;
  logic [DIV_W-1:0]         rem_q;
  logic [CW-1:0]            dig_q;
  logic signed [OUT_W-1:0]  res_q;

  logic [HALF_W-1:0] half;
  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] full;
  logic [7:0]        qd;
  logic [3:0]        r;
  logic [7:0]        top;
  logic [SW-1:0]     q_ext, sq, sum;
  logic              fits;
  logic [OUT_W-1:0]  sat;
  logic [OUT_W-1:0]  op_mag;

  assign op_mag = op_i.acc[OUT_W-1] ? OUT_W'(-op_i.acc) : OUT_W'(op_i.acc);

  // one multiplier: low half of the magnitude first, then the high half
  assign half = (st_q == U_MUL0) ? mag_q[HALF_W-1:0] : mag_q[MAG_W-1:HALF_W];
  assign prod = half * opnd_q;
  assign full = FULL_W'({prod, {HALF_W{1'b0}}}) + FULL_W'(prod_q)
              + (FULL_W'(d_q) << (FRAC_BITS - 1));

  // one quotient digit: eight compare-subtract steps on a tiny remainder
  assign top = quo_q[DW-1 -: 8];
  always_comb begin
    r  = {1'b0, rem_q};
    qd = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[2:0], top[i]};
      if (r >= {1'b0, d_q}) begin
        r     = r - {1'b0, d_q};
        qd[i] = 1'b1;
      end
    end
  end

  assign q_ext = {2'b00, quo_q};
  assign sq    = neg_q ? (~q_ext + SW'(1)) : q_ext;
  assign sum   = sq + {{(SW-COEF_W){add_q[COEF_W-1]}}, add_q};
  assign fits  = (sum[SW-1:OUT_W-1] == '0) || (sum[SW-1:OUT_W-1] == '1);
  assign sat   = fits ? sum[OUT_W-1:0]
               : (sum[SW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}});

  always_comb begin
    st_d = st_q;
    case (st_q)
      U_IDLE:  if (start_i) st_d = U_MUL0;
      U_MUL0:  st_d = U_MUL1;
      U_MUL1:  st_d = (d_q == DIV_W'(1)) ? U_FIN : U_DIV;
      U_DIV:   if (dig_q == CW'(ND - 1)) st_d = U_FIN;
      U_FIN:   st_d = U_IDLE;
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == U_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      U_IDLE: begin
        if (start_i) begin
          neg_q  <= op_i.acc[OUT_W-1] ^ op_i.flip;
          mag_q  <= op_mag;
          opnd_q <= op_i.opnd;
          d_q    <= op_i.div;
          add_q  <= op_i.addend;
        end
      end
      U_MUL0: prod_q <= prod;
      U_MUL1: begin
        quo_q <= DW'(full >> FRAC_BITS);
        rem_q <= '0;
        dig_q <= '0;
      end
      U_DIV: begin
        quo_q <= {quo_q[DW-9:0], qd};
        rem_q <= r[DIV_W-1:0];
        dig_q <= dig_q + CW'(1);
      end
      U_FIN: res_q <= sat;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* rtl/quintic_trajectory_point_evaluator_core.sv */
// ----------------------------------------------------------------------------
// quintic_trajectory_point_evaluator_core
// quintic trajectory position, scaled derivatives and scaled |jerk| sum at one sample time
// ----------------------------------------------------------------------------
// a new item is taken only once the previous result has moved to the result register,
//   as the single shared multiply/divide unit runs 18 operations per item in turn
// reset: coefficients clear to 0, amplitude to 1.0, jerk sum to 0, no result
module quintic_trajectory_point_evaluator_core import qtpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TIME_W-1:0]       sample_time_i,
  input  logic                    restart_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] position_o,
  output logic signed [OUT_W-1:0] velocity_o,
  output logic signed [OUT_W-1:0] acceleration_o,
  output logic signed [OUT_W-1:0] jerk_o,
  output logic signed [OUT_W-1:0] jerk_abs_sum_o,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [COEF_W-1:0]       cfg_data_i
);

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  qtpe_state_e st_q, st_d;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;

  // configuration registers
  logic signed [COEF_W-1:0] coef_q [NUM_COEF];
  logic signed [AMPI_W-1:0] amp_q;
  // running sum of |jerk|, always 0 .. OUT_MAX
  logic [OUT_W-1:0]         sum_q;

  // item in flight
  logic [TIME_W-1:0]       t_q;
  logic                    restart_q;
  logic signed [OUT_W-1:0] work_q;   // horner accumulator
  logic signed [OUT_W-1:0] pos_q, vel_q, acc_q, jrk_q, osum_q;

  // result register
  logic signed [OUT_W-1:0] out_pos_q, out_vel_q, out_acc_q, out_jrk_q, out_sum_q;

  qtpe_step_t              info;
  qtpe_op_t                op;
  logic                    start, done;
  logic signed [OUT_W-1:0] res;
  logic [OUT_W-1:0]        abs_j, base;
  logic [OUT_W:0]          sum_ext;
  logic [OUT_W-1:0]        sum_next;
  logic                    in_acc, out_free;
  logic [AMPI_W-1:0]       amp_mag;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign info     = step_info(step_q);
  assign amp_mag  = amp_q[AMPI_W-1] ? AMPI_W'(-amp_q) : AMPI_W'(amp_q);

  // operand select for the shared unit
  always_comb begin
    op.acc    = info.first ? {{(OUT_W-COEF_W){coef_q[0][COEF_W-1]}}, coef_q[0]} : work_q;
    op.opnd   = OPND_W'(t_q);
    op.flip   = 1'b0;
    op.div    = info.d;
    op.addend = coef_q[info.k];
    if (info.scale) begin
      case (info.dest)
        DST_VEL: op.acc = vel_q;
        DST_ACC: op.acc = acc_q;
        DST_JRK: op.acc = jrk_q;
        DST_SUM: op.acc = sum_q;
        default: op.acc = work_q;
      endcase
      op.opnd   = OPND_W'(amp_mag);
      op.flip   = amp_q[AMPI_W-1];
      op.div    = DIV_W'(1);
      op.addend = '0;
    end
  end

  qtpe_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op),
    .done_o (done),
    .res_o  (res)
  );

  // |jerk| with the most negative value counted as the largest positive
  assign abs_j    = !res[OUT_W-1] ? res : ((res == OUT_MIN) ? OUT_MAX : OUT_W'(-res));
  assign base     = restart_q ? '0 : sum_q;
  assign sum_ext  = {1'b0, base} + {1'b0, abs_j};
  assign sum_next = (sum_ext[OUT_W] || sum_ext[OUT_W-1]) ? OUT_MAX : sum_ext[OUT_W-1:0];

  // sequencer: issue one operation, wait for it, advance
  always_comb begin
    st_d  = st_q;
    start = 1'b0;
    case (st_q)
      ST_IDLE:  if (in_acc) st_d = ST_ISSUE;
      ST_ISSUE: begin
        start = 1'b1;
        st_d  = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) st_d = (step_q == STEP_W'(NUM_STEPS - 1)) ? ST_DRAIN : ST_ISSUE;
      end
      ST_DRAIN: if (out_free) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_acc) begin
        step_q <= '0;
      end else if (st_q == ST_WAIT && done) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (st_q == ST_DRAIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration and jerk sum state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
      amp_q <= AMPI_W'(1) << FRAC_BITS;
      sum_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CRACKLE_COEF:  coef_q[0] <= cfg_data_i;
          REG_SNAP_COEF:     coef_q[1] <= cfg_data_i;
          REG_JERK_COEF:     coef_q[2] <= cfg_data_i;
          REG_ACCEL_COEF:    coef_q[3] <= cfg_data_i;
          REG_VELOCITY_COEF: coef_q[4] <= cfg_data_i;
          REG_POSITION_COEF: coef_q[5] <= cfg_data_i;
          REG_AMPLITUDE:     amp_q <= {cfg_data_i[AMP_W-1], cfg_data_i[AMP_W-1:0]};
          default: ;
        endcase
      end
      // jerk is known once the jerk chain finishes, before its sum is scaled
      if (st_q == ST_WAIT && done && !info.scale && info.dest == DST_JRK) begin
        sum_q <= sum_next;
      end
    end
  end

  // item payload and unit results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q       <= sample_time_i;
      restart_q <= restart_i;
    end
    if (st_q == ST_WAIT && done) begin
      work_q <= res;
      case (info.dest)
        DST_POS: pos_q  <= res;
        DST_VEL: vel_q  <= res;
        DST_ACC: acc_q  <= res;
        DST_JRK: jrk_q  <= res;
        DST_SUM: osum_q <= res;
        default: ;
      endcase
    end
    if (st_q == ST_DRAIN && out_free) begin
      out_pos_q <= pos_q;
      out_vel_q <= vel_q;
      out_acc_q <= acc_q;
      out_jrk_q <= jrk_q;
      out_sum_q <= osum_q;
    end
  end

  assign in_ready_o     = (st_q == ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign position_o     = out_pos_q;
  assign velocity_o     = out_vel_q;
  assign acceleration_o = out_acc_q;
  assign jerk_o         = out_jrk_q;
  assign jerk_abs_sum_o = out_sum_q;

endmodule

/* rtl/qtpe_checker.sv */
// ----------------------------------------------------------------------------
// qtpe_checker
// port-level checks of the quintic point evaluator, bound to the top level
// ----------------------------------------------------------------------------
module qtpe_checker import qtpe_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] position_o,
  input logic signed [OUT_W-1:0] jerk_abs_sum_o
);

  // a stalled item stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // a result never appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result item too early");

  // payload of a stalled item holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(position_o) && $stable(jerk_abs_sum_o))
    else $error("result payload changed while stalled");

endmodule

bind quintic_trajectory_point_evaluator_core qtpe_checker u_qtpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .position_o    (position_o),
  .jerk_abs_sum_o(jerk_abs_sum_o)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// point-by-point check of the quintic trajectory evaluator against a local
// fixed-point predictor, over directed corner points and random time sweeps
// under several coefficient settings and handshake idling patterns
// ----------------------------------------------------------------------------
module testbench import qtpe_pkg::*; ();

  localparam int unsigned FRAC = 16;
  // settle time after the last result, longer than one item's evaluation
  localparam int unsigned DRAIN_CYCLES = 91 + 10 * ((64 - FRAC + 7) / 8) + 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned POINTS_PER_PHASE = 50;
  localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (OUT_W - 1));
  // index with no register behind it, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [TIME_W-1:0] stime;
    logic              restart;
  } traj_point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] position;
    logic signed [OUT_W-1:0] velocity;
    logic signed [OUT_W-1:0] acceleration;
    logic signed [OUT_W-1:0] jerk;
    logic signed [OUT_W-1:0] jerk_sum;
  } traj_result_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  // block ports
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [TIME_W-1:0]       sample_time = '0;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] position;
  logic signed [OUT_W-1:0] velocity;
  logic signed [OUT_W-1:0] acceleration;
  logic signed [OUT_W-1:0] jerk;
  logic signed [OUT_W-1:0] jerk_abs_sum;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [COEF_W-1:0]       cfg_data = '0;

  quintic_trajectory_point_evaluator_core #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_time_i (sample_time),
    .restart_i     (restart),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .position_o    (position),
    .velocity_o    (velocity),
    .acceleration_o(acceleration),
    .jerk_o        (jerk),
    .jerk_abs_sum_o(jerk_abs_sum),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // points waiting to be driven, and results the predictor has promised
  traj_point_t  points_to_send[$];
  traj_result_t results_due[$];

  // predictor copy of the block state, reset values
  longint coef_regs[NUM_COEF] = '{default: 0};
  longint amp_reg = longint'(1) <<< FRAC;
  longint abs_jerk_total = 0;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic point_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned points_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned results_checked = 0;
  int unsigned saturated_results = 0;
  int unsigned reg_writes = 0;
  int unsigned settings_loaded = 0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_out(longint x);
    if (x > OUT_HI) return OUT_HI;
    if (x < OUT_LO) return OUT_LO;
    return x;
  endfunction

  // one horner step with the factorial folded into the divisor:
  // clamp(c + round(acc * t / (d * 2^F))), rounding on the magnitude
  function automatic longint fold_term(longint acc, bit [63:0] t, int unsigned d,
                                       longint c);
    bit        neg;
    bit [63:0] mag;
    bit [63:0] den;
    bit [63:0] q;
    longint    r;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    den = 64'(d) << FRAC;
    q = (mag * t + (den >> 1)) / den;
    r = neg ? -longint'(q) : longint'(q);
    return clamp_out(r + c);
  endfunction

  // derivative chain of the given order, 5 gives position, 2 gives jerk
  function automatic longint poly_at(int unsigned order, bit [63:0] t);
    longint acc;
    acc = coef_regs[0];
    for (int unsigned k = 1; k <= order; k++)
      acc = fold_term(acc, t, order - k + 1, coef_regs[k]);
    return acc;
  endfunction

  function automatic longint amp_scaled(longint x);
    bit        neg;
    bit [63:0] mx;
    bit [63:0] ma;
    bit [63:0] p;
    neg = (x < 0) != (amp_reg < 0);
    mx = (x < 0) ? -x : x;
    ma = (amp_reg < 0) ? -amp_reg : amp_reg;
    p = (mx * ma + (64'd1 << (FRAC - 1))) >> FRAC;
    return clamp_out(neg ? -longint'(p) : longint'(p));
  endfunction

  // evaluates one point and advances the jerk sum
  function automatic traj_result_t evaluate_point(traj_point_t pt);
    traj_result_t r;
    bit [63:0]    t;
    longint       jrk;
    longint       jrk_mag;
    t = 64'(pt.stime);
    jrk = poly_at(2, t);
    // the most negative jerk counts as the largest positive one
    jrk_mag = (jrk < 0) ? ((jrk == OUT_LO) ? OUT_HI : -jrk) : jrk;
    if (pt.restart) abs_jerk_total = 0;
    abs_jerk_total = abs_jerk_total + jrk_mag;
    if (abs_jerk_total > OUT_HI) abs_jerk_total = OUT_HI;
    r.position     = OUT_W'(poly_at(5, t));
    r.velocity     = OUT_W'(amp_scaled(poly_at(4, t)));
    r.acceleration = OUT_W'(amp_scaled(poly_at(3, t)));
    r.jerk         = OUT_W'(amp_scaled(jrk));
    r.jerk_sum     = OUT_W'(amp_scaled(abs_jerk_total));
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [OUT_W-1:0] want,
                                      logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  function automatic bit is_saturated(traj_result_t r);
    return r.position == OUT_HI || r.position == OUT_LO
        || r.velocity == OUT_HI || r.velocity == OUT_LO
        || r.jerk == OUT_HI || r.jerk == OUT_LO
        || r.jerk_sum == OUT_HI || r.jerk_sum == OUT_LO;
  endfunction

  // --------------------------------------------------------------------------
  // driver: inputs change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    traj_point_t nxt;
    // receiver stalls are drawn every cycle
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || point_taken) begin
      // slot is free: either present the next point or leave a gap
      if (points_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt = points_to_send.pop_front();
        in_valid    <= 1'b1;
        sample_time <= nxt.stime;
        restart     <= nxt.restart;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: everything sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    traj_point_t  pt;
    traj_result_t want;
    traj_result_t due;
    if (rst_ni) begin
      // register writes update the predictor copy; only the low 24 bits of
      // the amplitude data count
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_AMPLITUDE)
          amp_reg = longint'($signed(cfg_data[AMP_W-1:0]));
        else if (cfg_index != REG_UNUSED)
          coef_regs[cfg_index] = longint'($signed(cfg_data));
      end

      // results are checked in order against the oldest prediction
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected, position %0d", $time, position);
        end else begin
          want = results_due.pop_front();
          check_field("position", want.position, position);
          check_field("velocity", want.velocity, velocity);
          check_field("acceleration", want.acceleration, acceleration);
          check_field("jerk", want.jerk, jerk);
          check_field("jerk_abs_sum", want.jerk_sum, jerk_abs_sum);
          results_checked++;
          if (is_saturated(want)) saturated_results++;
        end
      end

      // accepted point: predict now, with the state as of this edge
      if (in_valid && in_ready) begin
        pt.stime = sample_time;
        pt.restart = restart;
        due = evaluate_point(pt);
        results_due = {results_due, due};
        points_sent++;
        if (restart) restarts_sent++;
      end
      point_taken <= in_valid && in_ready;

      // watchdog on any handshake
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, results_due.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // full register set, only ever called with the block idle
  task automatic load_setting(input logic [COEF_W-1:0] c5, c4, c3, c2, c1, c0,
                              input logic [COEF_W-1:0] amp);
    write_reg(REG_CRACKLE_COEF, c5);
    write_reg(REG_SNAP_COEF, c4);
    write_reg(REG_JERK_COEF, c3);
    write_reg(REG_ACCEL_COEF, c2);
    write_reg(REG_VELOCITY_COEF, c1);
    write_reg(REG_POSITION_COEF, c0);
    write_reg(REG_AMPLITUDE, amp);
    settings_loaded++;
  endtask

  task automatic queue_point(input logic [TIME_W-1:0] t, input logic rs);
    traj_point_t p;
    p.stime = t;
    p.restart = rs;
    points_to_send = {points_to_send, p};
  endtask

  // mostly time sweeps that start with a restart, some loose random points
  task automatic queue_sweeps(input int unsigned count);
    int unsigned       left;
    int unsigned       seg;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] step;
    logic              clean_start;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99, 0) < 15) begin
        queue_point(TIME_W'($urandom), 1'($urandom_range(1, 0)));
        left--;
      end else begin
        seg = $urandom_range(16, 1);
        t = TIME_W'($urandom_range(32'h3_0000, 0));
        step = TIME_W'($urandom_range(32'h4000, 1));
        clean_start = ($urandom_range(9, 0) != 0);
        for (int unsigned i = 0; i < seg && left > 0; i++) begin
          queue_point(t, (i == 0) && clean_start);
          t = t + step;
          left--;
        end
      end
    end
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    int unsigned style;
    style = $urandom_range(9, 0);
    // mostly within +-16.0 so that short sweeps stay out of saturation
    if (style < 6) return COEF_W'($urandom_range(32'h1F_FFFF, 0)) - 32'h10_0000;
    if (style < 8) return COEF_W'($urandom);
    if (style == 8) return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return '0;
  endfunction

  function automatic logic [COEF_W-1:0] pick_amp();
    case ($urandom_range(6, 0))
      0: return 32'h0001_0000;
      1: return 32'h00FF_0000;
      2: return COEF_W'($urandom_range(32'h4_0000, 0)) - 32'h2_0000;
      3: return COEF_W'($urandom);
      4: return 32'h007F_FFFF;
      5: return 32'h0080_0000;
      default: return '0;
    endcase
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 28 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 28 : 0;
  endtask

  // wait for every queued point to come back, then let the block settle
  task automatic drain();
    while (points_to_send.size() != 0 || results_due.size() != 0 || in_valid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: zero coefficients, unit amplitude
    set_idling(IDLE_NONE);
    queue_point(24'h01_0000, 1'b1);
    queue_point(24'hFF_FFFF, 1'b0);
    drain();

    // moderate coefficients, negative half amplitude
    load_setting(32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0003_0000,
                 32'hFFFE_C000, 32'h000A_0000, 32'h00FF_8000);
    queue_point(24'h00_0000, 1'b1);
    queue_point(24'h00_0001, 1'b0);
    queue_point(24'h00_8000, 1'b0);
    queue_point(24'h01_0000, 1'b0);
    queue_point(24'h01_8000, 1'b0);
    queue_point(24'hFF_FFFF, 1'b0);
    queue_point(24'h80_0000, 1'b1);
    drain();

    // largest positive everything: every result field saturates, jerk sum pins at max
    load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h007F_FFFF);
    queue_point(24'hFF_FFFF, 1'b1);
    queue_point(24'hFF_FFFF, 1'b0);
    queue_point(24'hFF_FFFF, 1'b0);
    drain();

    // most negative everything: amplitude -128, scaled jerk reaches the positive limit
    load_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h0080_0000);
    queue_point(24'hFF_FFFF, 1'b1);
    queue_point(24'hFF_FFFF, 1'b0);
    queue_point(24'h00_0001, 1'b0);
    drain();

    // quartic loaded one register down; amplitude data with only upper bits
    // set reads as zero; a write to the empty index must change nothing
    load_setting(32'h0000_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000,
                 32'h0001_0000, 32'hFFF0_0000, 32'hFF00_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    queue_point(24'h02_0000, 1'b1);
    queue_point(24'h03_0000, 1'b0);
    drain();

    // random settings, sweeping through the idling patterns
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_setting(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                   pick_coef(), pick_coef(), pick_amp());
      if (ph % 3 == 1) write_reg(REG_UNUSED, COEF_W'($urandom));
      set_idling(idle_mode_e'(ph % 4));
      queue_sweeps(POINTS_PER_PHASE);
      drain();
    end

    if (results_due.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $time, results_due.size());
    end
    $display("covered %0d points (%0d with restart) over %0d settings, %0d register writes",
             points_sent, restarts_sent, settings_loaded, reg_writes);
    $display("checked %0d results, %0d with a saturated field, %0d mismatches",
             results_checked, saturated_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/qtpe_pkg.sv
rtl/qtpe_unit.sv
rtl/quintic_trajectory_point_evaluator_core.sv
rtl/qtpe_checker.sv
bench/testbench.sv
